// ===== hw/rtl/prrts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrts_pkg
// shared types, codes and default sizes of the task scheduler core
// ----------------------------------------------------------------------------
package prrts_pkg;

    localparam int DEF_MAX_TASKS      = 16;
    localparam int DEF_NUM_PRIORITIES = 8;

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_DELAY  = 2'd3;

    localparam logic [1:0] W_ABSENT  = 2'd0;
    localparam logic [1:0] W_READY   = 2'd1;
    localparam logic [1:0] W_BLOCKED = 2'd2;
    localparam logic [1:0] W_IDLE    = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_BSCAN = 5'b00010,
        S_HSCAN = 5'b00100,
        S_RWALK = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        P_START = 2'd0,
        P_TICK  = 2'd1,
        P_DELAY = 2'd2
    } t_purpose;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [31:0] sum;
        logic        eq;
    } t_alu_rsp;

endpackage

// ===== hw/rtl/prrts_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrts_alu
// shared 32-bit adder and equality compare for timer and wake times
// ----------------------------------------------------------------------------
module prrts_alu
    import prrts_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    assign o_rsp.sum = i_req.a + i_req.b;
    assign o_rsp.eq  = (i_req.a == i_req.b);

endmodule

// ===== hw/rtl/priority_round_robin_task_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler_core
// fixed priority preemptive round robin task scheduler
//
// channel  dir  payload (lowest bit up)
// s_axis   in   cmd[1:0] task_priority[4:2] delay_ticks[36:5]
// m_axis   out  status[0] task_id[4:1] switched[5]
//
// create needs no scan; start scans the priority levels one a cycle; tick walks
// the blocked tasks one a cycle, then scans the levels; delay walks the running
// task's fifo up to that task, then scans the levels. one request at a time; a
// result waits in the output register while the next request is taken. reset is
// synchronous and clears the state machine, task lists, timer and counts at once.
// ----------------------------------------------------------------------------
module priority_round_robin_task_scheduler_core
    import prrts_pkg::*;
#(
    parameter int MAX_TASKS      = DEF_MAX_TASKS,
    parameter int NUM_PRIORITIES = DEF_NUM_PRIORITIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // cmd, task_priority, delay_ticks
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata   // status, task_id, switched
);

    localparam int IW   = $clog2(MAX_TASKS + 1);
    localparam int IDXW = $clog2(MAX_TASKS);
    localparam int PW   = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam logic [IW-1:0] NO = IW'(MAX_TASKS);

    logic [2:0]      r_prio_of [MAX_TASKS];
    logic [31:0]     r_wake    [MAX_TASKS];
    logic [1:0]      r_where   [MAX_TASKS];
    logic [IW-1:0]   r_next    [MAX_TASKS];
    logic [IW-1:0]   r_head    [NUM_PRIORITIES];
    logic [IW-1:0]   r_tail    [NUM_PRIORITIES];
    logic [IDXW-1:0] r_blk     [MAX_TASKS];
    logic [IW-1:0]   r_blk_cnt, r_made, r_i, r_keep, r_cur, r_prev, r_guard, r_res_id;
    logic [31:0]     r_timer;
    logic [IDXW-1:0] r_run, r_idle;
    logic            r_started, r_ov, r_res_st, r_res_sw;
    logic [PW-1:0]   r_p;
    t_state          r_state;
    t_purpose        r_purp;

    logic [1:0]      in_cmd;
    logic [2:0]      in_prio;
    logic [31:0]     in_delay;
    logic            acc;
    t_alu_req        alu_req;
    t_alu_rsp        alu_rsp;
    logic [IDXW-1:0] bid;
    logic [PW-1:0]   run_p;
    logic [IW-1:0]   h, top_id, nxt;
    logic            found;
    logic            app_en;
    logic [IDXW-1:0] app_id;
    logic [PW-1:0]   app_p;

    assign in_cmd   = i_s_tdata[1:0];
    assign in_prio  = i_s_tdata[4:2];
    assign in_delay = i_s_tdata[36:5];
    assign o_s_tready = (r_state == S_IDLE);
    assign acc = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ov;

    assign bid    = r_blk[r_i[IDXW-1:0]];
    assign run_p  = PW'(r_prio_of[r_run]);
    assign h      = r_head[r_p];
    assign top_id = (h == NO) ? IW'(r_idle) : h;
    assign found  = (h != NO) || (r_p == '0);

    always_comb begin
        alu_req.a = r_timer;
        alu_req.b = 32'd1;
        if (r_state == S_BSCAN) begin
            alu_req.a = r_wake[bid];
            alu_req.b = r_timer;
        end else if (in_cmd == CMD_DELAY) begin
            alu_req.b = in_delay;
        end
    end

    prrts_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    always_comb begin
        app_en = 1'b0;
        app_id = r_made[IDXW-1:0];
        app_p  = PW'(in_prio);
        if (acc && in_cmd == CMD_CREATE && r_made != NO
                && 32'(in_prio) < NUM_PRIORITIES) begin
            app_en = 1'b1;
        end else if (r_state == S_BSCAN && r_i != r_blk_cnt && alu_rsp.eq) begin
            app_en = 1'b1;
            app_id = bid;
            app_p  = PW'(r_prio_of[bid]);
        end
    end

    always_comb begin
        nxt = IW'(r_run);
        if (r_prio_of[r_run] < r_prio_of[top_id[IDXW-1:0]]) begin
            nxt = top_id;
        end else if (r_where[r_run] == W_READY && r_next[r_run] != NO) begin
            nxt = r_next[r_run];
        end else begin
            nxt = top_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TASKS; k++) begin
                r_where[k] <= W_ABSENT;
                r_next[k]  <= NO;
            end
            for (int k = 0; k < NUM_PRIORITIES; k++) begin
                r_head[k] <= NO;
                r_tail[k] <= NO;
            end
            r_blk_cnt <= '0;
            r_made    <= '0;
            r_timer   <= '0;
            r_run     <= '0;
            r_idle    <= '0;
            r_started <= 1'b0;
            r_ov      <= 1'b0;
            r_state   <= S_IDLE;
            r_purp    <= P_START;
        end else begin
            if (r_ov && i_m_tready) begin
                r_ov <= 1'b0;
            end
            if (app_en) begin
                r_next[app_id]  <= NO;
                r_where[app_id] <= W_READY;
                r_tail[app_p]   <= IW'(app_id);
                if (r_head[app_p] == NO) begin
                    r_head[app_p] <= IW'(app_id);
                end else begin
                    r_next[r_tail[app_p][IDXW-1:0]] <= IW'(app_id);
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_res_st <= 1'b0;
                        r_res_sw <= 1'b0;
                        r_res_id <= IW'(r_run);
                        r_state  <= S_DONE;
                        case (in_cmd)
                            CMD_CREATE: begin
                                if (app_en) begin
                                    r_prio_of[r_made[IDXW-1:0]] <= in_prio;
                                    r_made   <= r_made + 1'b1;
                                    r_res_id <= r_made;
                                end else begin
                                    r_res_st <= 1'b1;
                                    r_res_id <= '0;
                                end
                            end
                            CMD_START: begin
                                if (r_started || r_made == NO) begin
                                    r_res_st <= 1'b1;
                                end else begin
                                    r_idle  <= r_made[IDXW-1:0];
                                    r_prio_of[r_made[IDXW-1:0]] <= 3'd0;
                                    r_next[r_made[IDXW-1:0]]    <= NO;
                                    r_where[r_made[IDXW-1:0]]   <= W_IDLE;
                                    r_made    <= r_made + 1'b1;
                                    r_started <= 1'b1;
                                    r_p     <= PW'(NUM_PRIORITIES - 1);
                                    r_purp  <= P_START;
                                    r_state <= S_HSCAN;
                                end
                            end
                            CMD_TICK: begin
                                r_timer <= alu_rsp.sum;
                                r_i     <= '0;
                                r_keep  <= '0;
                                r_state <= S_BSCAN;
                            end
                            default: begin
                                if (!r_started || r_where[r_run] != W_READY) begin
                                    r_res_st <= 1'b1;
                                end else begin
                                    r_wake[r_run] <= alu_rsp.sum;
                                    r_prev  <= NO;
                                    r_cur   <= r_head[run_p];
                                    r_guard <= '0;
                                    r_state <= S_RWALK;
                                end
                            end
                        endcase
                    end
                end
                S_BSCAN: begin
                    if (r_i == r_blk_cnt) begin
                        r_blk_cnt <= r_keep;
                        r_p       <= PW'(NUM_PRIORITIES - 1);
                        r_purp    <= P_TICK;
                        r_state   <= S_HSCAN;
                    end else begin
                        if (!alu_rsp.eq) begin
                            r_blk[r_keep[IDXW-1:0]] <= bid;
                            r_keep <= r_keep + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                S_RWALK: begin
                    if (r_cur != NO && r_cur != IW'(r_run) && r_guard != NO) begin
                        r_prev  <= r_cur;
                        r_cur   <= r_next[r_cur[IDXW-1:0]];
                        r_guard <= r_guard + 1'b1;
                    end else begin
                        if (r_cur == IW'(r_run)) begin
                            if (r_prev == NO) begin
                                r_head[run_p] <= r_next[r_run];
                            end else begin
                                r_next[r_prev[IDXW-1:0]] <= r_next[r_run];
                            end
                            if (r_tail[run_p] == IW'(r_run)) begin
                                r_tail[run_p] <= r_prev;
                            end
                            r_next[r_run] <= NO;
                        end
                        r_p     <= PW'(NUM_PRIORITIES - 1);
                        r_purp  <= P_DELAY;
                        r_state <= S_HSCAN;
                    end
                end
                S_HSCAN: begin
                    if (!found) begin
                        r_p <= r_p - 1'b1;
                    end else begin
                        r_state <= S_DONE;
                        case (r_purp)
                            P_START: begin
                                r_run    <= top_id[IDXW-1:0];
                                r_res_id <= top_id;
                            end
                            P_TICK: begin
                                if (r_started && nxt != IW'(r_run)) begin
                                    r_run    <= nxt[IDXW-1:0];
                                    r_res_id <= nxt;
                                    r_res_sw <= 1'b1;
                                end
                            end
                            default: begin
                                r_run    <= top_id[IDXW-1:0];
                                r_res_id <= top_id;
                                r_res_sw <= (top_id != IW'(r_run));
                                r_blk[r_blk_cnt[IDXW-1:0]] <= r_run;
                                r_blk_cnt <= r_blk_cnt + 1'b1;
                                r_where[r_run] <= W_BLOCKED;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (!r_ov || i_m_tready) begin
                        r_ov      <= 1'b1;
                        o_m_tdata <= {2'b00, r_res_sw, 4'(r_res_id), r_res_st};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_made_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_made <= NO) else $error("task count beyond table");

    a_blk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blk_cnt <= r_made) else $error("more blocked tasks than created");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_state != S_IDLE) else $error("request taken without work");

    a_idle_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> r_where[r_idle] == W_IDLE) else $error("idle task lost");

endmodule
